[sv/hsv_pkg.sv]
// shared types and constants for the rgb to hsv pixel converter
`default_nettype none
package hsv_pkg;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned QUOT_W     = 8;
  localparam int unsigned CELL_COUNT = QUOT_W;

  localparam int unsigned SECTOR_DEG = 60;
  localparam int unsigned GREEN_BASE = 120;
  localparam int unsigned BLUE_BASE  = 240;
  localparam int unsigned FULL_TURN  = 360;
  localparam int unsigned SAT_SCALE  = 255;

  localparam int unsigned SAT_REM_W  = 2 * CHAN_W;
  localparam int unsigned SAT_DSOR_W = CHAN_W + QUOT_W - 1;
  localparam int unsigned HUE_REM_W  = 2 * CHAN_W + 1;
  localparam int unsigned HUE_DSOR_W = CHAN_W + QUOT_W;

  typedef struct packed {
    logic [SAT_REM_W-1:0]  sat_rem;
    logic [SAT_DSOR_W-1:0] sat_dsor;
    logic [QUOT_W-1:0]     sat_q;
    logic [HUE_REM_W-1:0]  hue_rem;
    logic [HUE_DSOR_W-1:0] hue_dsor;
    logic [QUOT_W-1:0]     hue_q;
    logic [CHAN_W-1:0]     value;
  } hsv_beat_t;

endpackage
`default_nettype wire

[sv/hsv_front.sv]
// front stage: channel max and min, hue numerator and divisors
`default_nettype none
module hsv_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       up_valid,
  output logic                            up_ready,
  input  wire logic [hsv_pkg::CHAN_W-1:0] blue,
  input  wire logic [hsv_pkg::CHAN_W-1:0] green,
  input  wire logic [hsv_pkg::CHAN_W-1:0] red,
  output logic                            dn_valid,
  input  wire logic                       dn_ready,
  output hsv_pkg::hsv_beat_t              dn_data
);
  import hsv_pkg::*;

  localparam int unsigned NUM_W = HUE_REM_W + 2;

  logic                     valid_r;
  logic                     valid_nxt;
  hsv_beat_t                data_r;
  hsv_beat_t                data_nxt;
  logic [CHAN_W-1:0]        vmax;
  logic [CHAN_W-1:0]        vmin;
  logic [CHAN_W-1:0]        span;
  logic signed [NUM_W-1:0]  sd;
  logic signed [NUM_W-1:0]  sb;
  logic signed [NUM_W-1:0]  sg;
  logic signed [NUM_W-1:0]  sr;
  logic signed [NUM_W-1:0]  num;
  logic signed [NUM_W-1:0]  num_wrap;
  logic [CHAN_W-1:0]        sat_d;
  logic [CHAN_W:0]          hue_d;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    vmax = (red > green) ? red : green;
    vmax = (vmax > blue) ? vmax : blue;
    vmin = (red < green) ? red : green;
    vmin = (vmin < blue) ? vmin : blue;
    span = vmax - vmin;
    sd = signed'(NUM_W'(span));
    sb = signed'(NUM_W'(blue));
    sg = signed'(NUM_W'(green));
    sr = signed'(NUM_W'(red));
    if (vmax == red) begin
      num = NUM_W'(SECTOR_DEG) * (sg - sb);
    end else if (vmax == green) begin
      num = NUM_W'(GREEN_BASE) * sd + NUM_W'(SECTOR_DEG) * (sb - sr);
    end else begin
      num = NUM_W'(BLUE_BASE) * sd + NUM_W'(SECTOR_DEG) * (sr - sg);
    end
    num_wrap = (num < 0) ? (num + NUM_W'(FULL_TURN) * sd) : num;
    // zero dividend with a nonzero divisor gives a zero quotient
    sat_d = (vmax == '0) ? CHAN_W'(1) : vmax;
    hue_d = (span == '0) ? (CHAN_W+1)'(1) : {span, 1'b0};

    data_nxt          = data_r;
    data_nxt.sat_rem  = SAT_REM_W'(SAT_SCALE) * SAT_REM_W'(span);
    data_nxt.sat_dsor = {sat_d, (QUOT_W-1)'(0)};
    data_nxt.sat_q    = '0;
    data_nxt.hue_rem  = HUE_REM_W'(num_wrap);
    data_nxt.hue_dsor = {hue_d, (QUOT_W-1)'(0)};
    data_nxt.hue_q    = '0;
    data_nxt.value    = vmax;
    valid_nxt = up_ready ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule
`default_nettype wire

[sv/hsv_div_cell.sv]
// one cell of the divider chain: one quotient bit of saturation and hue
`default_nettype none
module hsv_div_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire hsv_pkg::hsv_beat_t up_data,
  output logic                    dn_valid,
  input  wire logic               dn_ready,
  output hsv_pkg::hsv_beat_t      dn_data
);
  import hsv_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  hsv_beat_t data_r;
  hsv_beat_t data_nxt;
  logic      sat_take;
  logic      hue_take;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    sat_take = up_data.sat_rem >= SAT_REM_W'(up_data.sat_dsor);
    hue_take = up_data.hue_rem >= HUE_REM_W'(up_data.hue_dsor);
    data_nxt          = up_data;
    data_nxt.sat_rem  = sat_take ? (up_data.sat_rem - SAT_REM_W'(up_data.sat_dsor))
                                 : up_data.sat_rem;
    data_nxt.hue_rem  = hue_take ? (up_data.hue_rem - HUE_REM_W'(up_data.hue_dsor))
                                 : up_data.hue_rem;
    data_nxt.sat_dsor = up_data.sat_dsor >> 1;
    data_nxt.hue_dsor = up_data.hue_dsor >> 1;
    data_nxt.sat_q    = {up_data.sat_q[QUOT_W-2:0], sat_take};
    data_nxt.hue_q    = {up_data.hue_q[QUOT_W-2:0], hue_take};
    valid_nxt = up_ready ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule
`default_nettype wire

[sv/rgb_to_hsv_pixel_converter_unit.sv]
// top level of the rgb to hsv pixel converter
// Accepts one pixel per clock unless a full pipeline is held by out_tready, and returns
// hue (half degrees, 0 to 179), saturation and value. One front stage finds max, min
// and the hue numerator, then a chain of eight divider cells each settles one quotient
// bit of both saturation and hue. Every stage holds its own beat, so bubbles close up
// and input is taken while a finished result waits at the output, as long as a stage is empty.
`default_nettype none
module rgb_to_hsv_pixel_converter_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // blue [7:0], green [15:8], red [23:16]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // hue [7:0], saturation [15:8], brightness [23:16]
);
  import hsv_pkg::*;

  logic      stg_valid [CELL_COUNT+1];
  logic      stg_ready [CELL_COUNT+1];
  hsv_beat_t stg_data  [CELL_COUNT+1];

  hsv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .blue     (in_tdata[7:0]),
    .green    (in_tdata[15:8]),
    .red      (in_tdata[23:16]),
    .dn_valid (stg_valid[0]),
    .dn_ready (stg_ready[0]),
    .dn_data  (stg_data[0])
  );

  for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
    hsv_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[i]),
      .up_ready (stg_ready[i]),
      .up_data  (stg_data[i]),
      .dn_valid (stg_valid[i+1]),
      .dn_ready (stg_ready[i+1]),
      .dn_data  (stg_data[i+1])
    );
  end

  assign stg_ready[CELL_COUNT] = out_tready;
  assign out_tvalid = stg_valid[CELL_COUNT];
  assign out_tdata  = {stg_data[CELL_COUNT].value,
                       stg_data[CELL_COUNT].sat_q,
                       stg_data[CELL_COUNT].hue_q};

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:0] < 8'd180))
    else $error("hue out of range");

  a_black_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[23:16] == 8'd0) |-> (out_tdata[15:8] == 8'd0))
    else $error("black pixel with nonzero saturation");

  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[15:8] == 8'd0) |-> (out_tdata[7:0] == 8'd0))
    else $error("grey pixel with nonzero hue");

endmodule
`default_nettype wire
